// ----- rtl/tsua_pkg.sv -----
// ----------------------------------------------------------------------------
// tsua_pkg
// Shared types and constants for the TDMA slot user allocator.
// ----------------------------------------------------------------------------
package tsua_pkg;

  // Default configuration of the slot frame
  localparam int DEF_SLOTS      = 16;
  localparam int DEF_MIN_PERIOD = 4;
  localparam int DEF_MAX_USERS  = 256;

  localparam int TAG_W    = 64;
  localparam int PERIOD_W = 4;
  localparam int OFFSET_W = 12;
  localparam int RA_W     = 5;
  localparam int CFG_W    = 64;

  // Request operations
  localparam logic OP_PLACE  = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SLOT_PERIODS = 1'b0;
  localparam logic CFG_RA_COUNT     = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [TAG_W-1:0]    tag_id;
    logic [PERIOD_W-1:0] period;
  } req_t;

  typedef struct packed {
    logic                ok;
    logic [OFFSET_W-1:0] tx_offset;
  } rsp_t;

endpackage

// ----- rtl/tdma_slot_user_allocator.sv -----
// ----------------------------------------------------------------------------
// tdma_slot_user_allocator
// Places and removes tags in the user positions of a TDMA subframe.
// ----------------------------------------------------------------------------
// A request walks the slots in index order under a small sequencer that reads
// one position of the occupancy store per cycle. A skipped slot is passed in
// ST_SLOT, and a scanned slot is checked in ST_CHECK position by position
// until a hit or the end of its capacity; the result then waits in ST_DONE
// for the output register, and the sequencer returns to ST_IDLE to take the
// next request. The occupancy store has a single read port. After reset and
// after every configuration write all SLOTS*MAX_USERS entries of the store
// are swept clear, one entry per cycle, and no request is taken meanwhile;
// configuration writes are always taken, and no request is taken in a cycle
// that offers one. A finished result sits in an output register so the next
// request can start while it waits.
module tdma_slot_user_allocator #(
  parameter int SLOTS      = tsua_pkg::DEF_SLOTS,
  parameter int MIN_PERIOD = tsua_pkg::DEF_MIN_PERIOD,
  parameter int MAX_USERS  = tsua_pkg::DEF_MAX_USERS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  tsua_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output tsua_pkg::rsp_t             rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [tsua_pkg::CFG_W-1:0] cfg_data
);

  localparam int DEPTH  = SLOTS * MAX_USERS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int POS_W  = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int CAP_W  = $clog2(MAX_USERS + 1);
  localparam int CMP_W  = CAP_W + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_SLOT  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  typedef struct packed {
    logic                       used;
    logic [tsua_pkg::TAG_W-1:0] tag;
  } entry_t;

  logic [2:0]                    state;
  logic [ADDR_W-1:0]             clr_addr;
  logic [SLOT_W-1:0]             slot;
  logic [POS_W-1:0]              pos;
  logic                          op;
  logic [tsua_pkg::TAG_W-1:0]    tag;
  logic [tsua_pkg::PERIOD_W-1:0] want;
  logic                          res_ok;
  logic [tsua_pkg::OFFSET_W-1:0] res_off;
  logic [63:0]                   slot_periods;
  logic [tsua_pkg::RA_W-1:0]     ra_count;

  entry_t                        mem [DEPTH];
  entry_t                        rd_entry;

  logic [tsua_pkg::PERIOD_W-1:0] period_cur;
  logic [16:0]                   pow_cur;
  logic [CAP_W-1:0]              cap_cur;
  logic                          slot_skip;
  logic                          last_slot;
  logic [POS_W-1:0]              pos_rd;
  logic [ADDR_W-1:0]             rd_addr;
  logic [ADDR_W-1:0]             cur_addr;
  logic                          hit;
  logic                          more;
  logic                          mem_we;
  logic [ADDR_W-1:0]             wr_addr;
  entry_t                        wr_entry;
  logic                          rsp_load;

  // Capacity of the current slot
  always_comb begin
    period_cur = slot_periods[6'(slot) * 6'd4 +: 4];
    pow_cur    = 17'd1 << (period_cur - 4'(MIN_PERIOD));
    if (5'(slot) <= ra_count || period_cur < 4'(MIN_PERIOD)) begin
      cap_cur = '0;
    end else if (pow_cur > 17'(MAX_USERS)) begin
      cap_cur = CAP_W'(MAX_USERS);
    end else begin
      cap_cur = CAP_W'(pow_cur);
    end
    slot_skip = (op == tsua_pkg::OP_PLACE && period_cur != want) || cap_cur == '0;
    last_slot = slot == SLOT_W'(SLOTS - 1);
  end

  // Position address slot + pos*SLOTS; read runs one position ahead
  always_comb begin
    pos_rd   = (state == ST_CHECK) ? pos + POS_W'(1) : '0;
    rd_addr  = ADDR_W'(slot) + ADDR_W'(pos_rd) * ADDR_W'(SLOTS);
    cur_addr = ADDR_W'(slot) + ADDR_W'(pos) * ADDR_W'(SLOTS);
    more     = (CMP_W'(pos) + CMP_W'(1)) < CMP_W'(cap_cur);
    if (op == tsua_pkg::OP_PLACE) begin
      hit = !rd_entry.used;
    end else begin
      hit = rd_entry.used && rd_entry.tag == tag;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    wr_addr = cur_addr;
    wr_entry.used = (op == tsua_pkg::OP_PLACE);
    wr_entry.tag = tag;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
      wr_addr = clr_addr;
      wr_entry.used = 1'b0;
    end else if (state == ST_CHECK && hit) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

  assign req_stall = (state != ST_IDLE) || cfg_valid;
  assign cfg_ready = 1'b1;
  // result moves into the output register once that register is free and no configuration write is offered
  assign rsp_load  = (state == ST_DONE) && (!rsp_valid || !rsp_stall) && !cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      rsp_valid    <= 1'b0;
      slot_periods <= '0;
      ra_count     <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      // any register write frees every position
      if (cfg_valid) begin
        unique case (cfg_index)
          tsua_pkg::CFG_SLOT_PERIODS: slot_periods <= cfg_data;
          tsua_pkg::CFG_RA_COUNT:     ra_count <= cfg_data[tsua_pkg::RA_W-1:0];
          default: ;
        endcase
        clr_addr <= '0;
        state    <= ST_CLEAR;
      end else begin
        unique case (state)
          ST_IDLE: begin
            if (req_valid) begin
              op    <= req.operation;
              tag   <= req.tag_id;
              want  <= req.period;
              slot  <= '0;
              state <= ST_SLOT;
            end
          end
          ST_CLEAR: begin
            clr_addr <= clr_addr + ADDR_W'(1);
            if (clr_addr == ADDR_W'(DEPTH - 1)) begin
              state <= ST_IDLE;
            end
          end
          ST_SLOT: begin
            if (!slot_skip) begin
              pos   <= '0;
              state <= ST_CHECK;
            end else if (last_slot) begin
              res_ok  <= 1'b0;
              res_off <= '0;
              state   <= ST_DONE;
            end else begin
              slot <= slot + SLOT_W'(1);
            end
          end
          ST_CHECK: begin
            if (hit) begin
              res_ok  <= 1'b1;
              res_off <= (op == tsua_pkg::OP_PLACE) ?
                         tsua_pkg::OFFSET_W'(cur_addr) : '0;
              state   <= ST_DONE;
            end else if (more) begin
              pos <= pos + POS_W'(1);
            end else if (last_slot) begin
              res_ok  <= 1'b0;
              res_off <= '0;
              state   <= ST_DONE;
            end else begin
              slot  <= slot + SLOT_W'(1);
              state <= ST_SLOT;
            end
          end
          ST_DONE: begin
            // wait for the output register to free up
            if (rsp_load) begin
              rsp.ok        <= res_ok;
              rsp.tx_offset <= res_off;
              state         <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

  a_cfg_starts_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> req_stall)
    else $error("request taken right after a register write");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request taken before the clearing sweep");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken while one is in progress");

  a_fail_zero_offset: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.tx_offset == '0)
    else $error("failed request reports a nonzero offset");

endmodule
